// ===== hw/rtl/dfvt_pkg.sv =====
// ----------------------------------------------------------------------------
// dfvt_pkg
// Shared types and constants for the dirty frame version tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfvt_pkg;

  localparam int FRAMES_DEF  = 1024;
  localparam int INDEX_W     = 16;
  localparam int VER_W       = 32;
  localparam int FRAME_OUT_W = 10;

  localparam logic [VER_W-1:0] VER_STEP = 32'd2;

  typedef enum logic [1:0] {
    OP_COMMIT   = 2'd0,
    OP_TAKE     = 2'd1,
    OP_CONFIRM  = 2'd2,
    OP_ROLLBACK = 2'd3
  } op_t;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_COMMIT = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_COPY   = 7'b0010000,
    ST_FINISH = 7'b0100000,
    ST_SPARE  = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dfvt_ram.sv =====
// ----------------------------------------------------------------------------
// dfvt_ram
// Simple dual-port version store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfvt_ram
  import dfvt_pkg::*;
#(
  parameter int DEPTH = FRAMES_DEF,
  parameter int AW    = $clog2(FRAMES_DEF),
  parameter int DW    = VER_W
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dfvt_seq.sv =====
// ----------------------------------------------------------------------------
// dfvt_seq
// Sequencer: drives the version stores one frame per cycle through a shared
// address stepper and version compare, and holds the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfvt_seq
  import dfvt_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF,
  parameter int IW     = $clog2(FRAMES)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_op,
  input  wire logic [INDEX_W-1:0]     in_frame_index,
  input  wire logic [VER_W-1:0]       in_version,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_ok,
  output logic [FRAME_OUT_W-1:0]      out_changed_frame,
  output logic [VER_W-1:0]            out_found_version,
  output logic                        wv_we,
  output logic [IW-1:0]               wv_waddr,
  output logic [VER_W-1:0]            wv_wdata,
  output logic [IW-1:0]               wv_raddr,
  input  wire logic [VER_W-1:0]       wv_rdata,
  output logic                        ov_we,
  output logic [IW-1:0]               ov_waddr,
  output logic [VER_W-1:0]            ov_wdata,
  output logic [IW-1:0]               ov_raddr,
  input  wire logic [VER_W-1:0]       ov_rdata,
  output logic                        cm_we,
  output logic [IW-1:0]               cm_waddr,
  output logic [VER_W-1:0]            cm_wdata,
  output logic [IW-1:0]               cm_raddr,
  input  wire logic [VER_W-1:0]       cm_rdata
);

  localparam logic [IW-1:0]      LAST     = IW'(FRAMES - 1);
  localparam logic [IW:0]        CNT_FULL = (IW+1)'(FRAMES);
  localparam logic [INDEX_W:0]   FRAMES_X = (INDEX_W+1)'(FRAMES);

  state_t               state_r, state_nxt;
  logic [IW-1:0]        ptr_r, ptr_nxt;
  logic [IW:0]          cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [IW-1:0]        pend_addr_r, pend_addr_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        scan_pos_r, scan_pos_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [IW-1:0]        res_frame_r, res_frame_nxt;
  logic [VER_W-1:0]     res_ver_r, res_ver_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_ok_r;
  logic [FRAME_OUT_W-1:0] out_frame_r;
  logic [VER_W-1:0]     out_ver_r;

  logic                 accept;
  logic                 in_range;
  logic                 issue;
  logic                 differ;
  logic                 load_out;
  logic [IW-1:0]        ptr_step;
  logic [IW-1:0]        pend_step;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    logic [IW-1:0] r;
    r = (a == LAST) ? '0 : a + IW'(1);
    return r;
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_range  = ({1'b0, in_frame_index} < FRAMES_X);
  assign issue     = (cnt_r != CNT_FULL);
  assign differ    = (wv_rdata != ov_rdata);
  assign ptr_step  = wrap_inc(ptr_r);
  assign pend_step = wrap_inc(pend_addr_r);
  assign load_out  = (state_r == ST_FINISH) && (!out_valid_r || out_ready);

  // store ports
  always_comb begin
    wv_we    = (state_r == ST_CLEAR) || (state_r == ST_COMMIT);
    wv_waddr = (state_r == ST_CLEAR) ? ptr_r : idx_r;
    wv_wdata = (state_r == ST_CLEAR) ? '0 : wv_rdata + VER_STEP;
    wv_raddr = (state_r == ST_IDLE) ? in_frame_index[IW-1:0] : ptr_r;

    ov_we    = (state_r == ST_CLEAR) ||
               ((state_r == ST_SCAN) && pend_r && differ) ||
               ((state_r == ST_COPY) && pend_r);
    ov_waddr = (state_r == ST_CLEAR) ? ptr_r : pend_addr_r;
    ov_wdata = (state_r == ST_CLEAR) ? '0 :
               ((state_r == ST_COPY) ? cm_rdata : wv_rdata);
    ov_raddr = ptr_r;

    cm_we    = (state_r == ST_CLEAR) ||
               (accept && (op_t'(in_op) == OP_CONFIRM) && in_range);
    cm_waddr = (state_r == ST_CLEAR) ? ptr_r : in_frame_index[IW-1:0];
    cm_wdata = (state_r == ST_CLEAR) ? '0 : in_version;
    cm_raddr = ptr_r;
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    idx_nxt       = idx_r;
    scan_pos_nxt  = scan_pos_r;
    res_ok_nxt    = res_ok_r;
    res_frame_nxt = res_frame_r;
    res_ver_nxt   = res_ver_r;

    case (state_r)
      ST_CLEAR: begin
        ptr_nxt = ptr_step;
        if (ptr_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          idx_nxt       = in_frame_index[IW-1:0];
          res_ok_nxt    = 1'b0;
          res_frame_nxt = '0;
          res_ver_nxt   = '0;
          cnt_nxt       = '0;
          pend_nxt      = 1'b0;
          case (op_t'(in_op))
            OP_COMMIT: begin
              if (in_range) begin
                state_nxt = ST_COMMIT;
              end else begin
                state_nxt = ST_FINISH;
              end
            end
            OP_TAKE: begin
              ptr_nxt   = scan_pos_r;
              state_nxt = ST_SCAN;
            end
            OP_CONFIRM: begin
              res_ok_nxt = in_range;
              state_nxt  = ST_FINISH;
            end
            OP_ROLLBACK: begin
              ptr_nxt      = '0;
              scan_pos_nxt = '0;
              state_nxt    = ST_COPY;
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end
      ST_COMMIT: begin
        res_ok_nxt = 1'b1;
        state_nxt  = ST_FINISH;
      end
      ST_SCAN, ST_COPY: begin
        pend_nxt      = issue;
        pend_addr_nxt = ptr_r;
        if (issue) begin
          ptr_nxt = ptr_step;
          cnt_nxt = cnt_r + (IW+1)'(1);
        end
        if (pend_r) begin
          if (state_r == ST_SCAN) begin
            if (differ) begin
              scan_pos_nxt  = pend_step;
              res_ok_nxt    = 1'b1;
              res_frame_nxt = pend_addr_r;
              res_ver_nxt   = wv_rdata;
              state_nxt     = ST_FINISH;
            end else if (!issue) begin
              state_nxt = ST_FINISH;
            end
          end else if (!issue) begin
            res_ok_nxt = 1'b1;
            state_nxt  = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ptr_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      scan_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      scan_pos_r  <= scan_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    idx_r       <= idx_nxt;
    res_ok_r    <= res_ok_nxt;
    res_frame_r <= res_frame_nxt;
    res_ver_r   <= res_ver_nxt;
    if (load_out) begin
      out_ok_r    <= res_ok_r;
      out_frame_r <= FRAME_OUT_W'(res_frame_r);
      out_ver_r   <= res_ver_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_changed_frame = out_frame_r;
  assign out_found_version = out_ver_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dirty_frame_version_tracker.sv =====
// The take scan and rollback copy step one frame per cycle through the version
//   stores' single read port.
// Throughput: one word at a time; next word taken once the result is loaded.
// Reset: synchronous, active low; a clearing pass then zeroes
//   all three version stores, with in_ready low throughout.
// ----------------------------------------------------------------------------
// dirty_frame_version_tracker
// Per-frame write / observed / confirmed versions with round-robin take scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dirty_frame_version_tracker
  import dfvt_pkg::*;
#(
  parameter int FRAMES = FRAMES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_op,
  input  wire logic [INDEX_W-1:0]     in_frame_index,
  input  wire logic [VER_W-1:0]       in_version,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_ok,
  output logic [FRAME_OUT_W-1:0]      out_changed_frame,
  output logic [VER_W-1:0]            out_found_version
);

  localparam int IW = $clog2(FRAMES);

  logic             wv_we, ov_we, cm_we;
  logic [IW-1:0]    wv_waddr, ov_waddr, cm_waddr;
  logic [IW-1:0]    wv_raddr, ov_raddr, cm_raddr;
  logic [VER_W-1:0] wv_wdata, ov_wdata, cm_wdata;
  logic [VER_W-1:0] wv_rdata, ov_rdata, cm_rdata;

  dfvt_seq #(
    .FRAMES (FRAMES),
    .IW     (IW)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_frame_index    (in_frame_index),
    .in_version        (in_version),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_changed_frame (out_changed_frame),
    .out_found_version (out_found_version),
    .wv_we             (wv_we),
    .wv_waddr          (wv_waddr),
    .wv_wdata          (wv_wdata),
    .wv_raddr          (wv_raddr),
    .wv_rdata          (wv_rdata),
    .ov_we             (ov_we),
    .ov_waddr          (ov_waddr),
    .ov_wdata          (ov_wdata),
    .ov_raddr          (ov_raddr),
    .ov_rdata          (ov_rdata),
    .cm_we             (cm_we),
    .cm_waddr          (cm_waddr),
    .cm_wdata          (cm_wdata),
    .cm_raddr          (cm_raddr),
    .cm_rdata          (cm_rdata)
  );

  dfvt_ram #(.DEPTH(FRAMES), .AW(IW), .DW(VER_W)) u_write_ver (
    .clk   (clk),
    .we    (wv_we),
    .waddr (wv_waddr),
    .wdata (wv_wdata),
    .raddr (wv_raddr),
    .rdata (wv_rdata)
  );

  dfvt_ram #(.DEPTH(FRAMES), .AW(IW), .DW(VER_W)) u_obs_ver (
    .clk   (clk),
    .we    (ov_we),
    .waddr (ov_waddr),
    .wdata (ov_wdata),
    .raddr (ov_raddr),
    .rdata (ov_rdata)
  );

  dfvt_ram #(.DEPTH(FRAMES), .AW(IW), .DW(VER_W)) u_conf_ver (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dfvt_checker.sv =====
// ----------------------------------------------------------------------------
// dfvt_props
// Port-level checks for the dirty frame version tracker, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfvt_props
  import dfvt_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic                   out_ok,
  input wire logic [FRAME_OUT_W-1:0] out_changed_frame,
  input wire logic [VER_W-1:0]       out_found_version
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) &&
      $stable(out_changed_frame) && $stable(out_found_version))
    else $error("result word changed while stalled");

  // store clearing pass follows reset
  a_clear_busy: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("ready during clearing pass");

  // one word in flight
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while busy");

  // not-ok words carry zero fields
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_changed_frame == '0 && out_found_version == '0)
    else $error("fields set on not-ok word");

  // write versions are always even
  a_even_ver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_found_version[0])
    else $error("odd version reported");

endmodule

bind dirty_frame_version_tracker dfvt_props u_dfvt_props (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_ok            (out_ok),
  .out_changed_frame (out_changed_frame),
  .out_found_version (out_found_version)
);

`default_nettype wire

// ===== bench/dfvt_checker.sv =====
// ----------------------------------------------------------------------------
// dfvt_checker
// Watches both channels of the dirty frame version tracker. Each accepted
// input word updates a private copy of the version stores and the scan cursor
// and queues the expected result word. Each accepted result word is checked
// in order against the oldest expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dfvt_checker
  import dfvt_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic [1:0]             in_op,
  input  wire logic [INDEX_W-1:0]     in_frame_index,
  input  wire logic [VER_W-1:0]       in_version,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic                   out_ok,
  input  wire logic [FRAME_OUT_W-1:0] out_changed_frame,
  input  wire logic [VER_W-1:0]       out_found_version,
  output int                          mismatches,
  output int                          pending
);

  localparam int NF = FRAMES_DEF;

  typedef struct packed {
    logic                   ok;
    logic [FRAME_OUT_W-1:0] frame;
    logic [VER_W-1:0]       ver;
  } sync_word_t;

  logic [VER_W-1:0] wr_ver   [NF];
  logic [VER_W-1:0] seen_ver [NF];
  logic [VER_W-1:0] acked_ver[NF];
  int unsigned      cursor;

  sync_word_t       due_words[$];

  initial begin
    for (int i = 0; i < NF; i++) begin
      wr_ver[i]    = '0;
      seen_ver[i]  = '0;
      acked_ver[i] = '0;
    end
    cursor     = 0;
    mismatches = 0;
    pending    = 0;
  end

  function automatic sync_word_t track_frames(op_t op, logic [INDEX_W-1:0] idx,
                                              logic [VER_W-1:0] ver);
    sync_word_t  res;
    int unsigned cand;
    res = '0;
    case (op)
      OP_COMMIT: begin
        if (idx < NF) begin
          wr_ver[idx] = wr_ver[idx] + VER_STEP;
          res.ok = 1'b1;
        end
      end
      OP_TAKE: begin
        for (int n = 0; n < NF; n++) begin
          cand   = cursor;
          cursor = (cand + 1) % NF;
          if (wr_ver[cand] != seen_ver[cand]) begin
            seen_ver[cand] = wr_ver[cand];
            res.ok    = 1'b1;
            res.frame = cand[FRAME_OUT_W-1:0];
            res.ver   = wr_ver[cand];
            break;
          end
        end
      end
      OP_CONFIRM: begin
        if (idx < NF) begin
          acked_ver[idx] = ver;
          res.ok = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < NF; i++) seen_ver[i] = acked_ver[i];
        cursor = 0;
        res.ok = 1'b1;
      end
    endcase
    return res;
  endfunction

  task automatic flag(string what, sync_word_t exp, sync_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp ok=%0b frame=%0d ver=%h, got ok=%0b frame=%0d ver=%h",
               $realtime, what, exp.ok, exp.frame, exp.ver, got.ok, got.frame, got.ver);
  endtask

  always @(posedge clk) begin
    sync_word_t got;
    sync_word_t exp;
    if (rst_n) begin
      if (in_valid && in_ready)
        due_words.push_back(track_frames(op_t'(in_op), in_frame_index, in_version));
      if (out_valid && out_ready) begin
        got = '{out_ok, out_changed_frame, out_found_version};
        if (due_words.size() == 0) begin
          flag("unexpected word", '0, got);
        end else begin
          exp = due_words.pop_front();
          if (got !== exp) flag("word mismatch", exp, got);
        end
      end
    end
    pending <= due_words.size();
  end

endmodule

// ===== bench/tb_dirty_frame_version_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_dirty_frame_version_tracker
// Drives the tracker with directed corner words, then rounds of commits,
// takes and confirms with occasional rollbacks and random noise, under random
// gaps on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_dirty_frame_version_tracker;
  import dfvt_pkg::*;

  localparam int RAND_WORDS = 550;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             in_op;
  logic [INDEX_W-1:0]     in_frame_index;
  logic [VER_W-1:0]       in_version;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_ok;
  logic [FRAME_OUT_W-1:0] out_changed_frame;
  logic [VER_W-1:0]       out_found_version;

  int                     mismatches;
  int                     pending;
  int                     sent;
  bit                     steady;

  always #6 clk = ~clk;

  dirty_frame_version_tracker #(.FRAMES(FRAMES_DEF)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_frame_index   (in_frame_index),
    .in_version       (in_version),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_changed_frame(out_changed_frame),
    .out_found_version(out_found_version)
  );

  dfvt_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_frame_index   (in_frame_index),
    .in_version       (in_version),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_ok           (out_ok),
    .out_changed_frame(out_changed_frame),
    .out_found_version(out_found_version),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [INDEX_W-1:0] pick_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return INDEX_W'($urandom_range(0, 15));
    if (r < 80) return INDEX_W'($urandom_range(0, FRAMES_DEF - 1));
    if (r < 88) return ($urandom_range(0, 1) != 0) ? INDEX_W'(FRAMES_DEF - 1) : '0;
    return INDEX_W'($urandom_range(FRAMES_DEF, 65535));
  endfunction

  function automatic logic [VER_W-1:0] pick_version();
    if ($urandom_range(0, 1) != 0) return VER_W'($urandom_range(0, 40) * 2);
    return $urandom;
  endfunction

  // called at a rising edge; returns at the edge that accepts the word
  task automatic send_word(op_t op, logic [INDEX_W-1:0] idx, logic [VER_W-1:0] ver);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_frame_index <= idx;
    in_version     <= ver;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic push_word(op_t op, logic [INDEX_W-1:0] idx, logic [VER_W-1:0] ver);
    int g;
    send_word(op, idx, ver);
    sent++;
    steady = (sent >= 250 && sent < 330);
    g = pick_gap();
    if (sent % 120 == 0) begin
      in_valid <= 1'b0;
      drain();
    end else if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      int stall;
      int run;
      stall = pick_gap();
      repeat (stall) begin
        @(posedge clk);
        out_ready <= 1'b0;
      end
      run = $urandom_range(1, 30);
      repeat (run) begin
        @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int   k;
    int   m;
    int   start;
    op_t  op;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_COMMIT;
    in_frame_index = '0;
    in_version     = '0;
    sent           = 0;
    steady         = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // corners: range edges, empty scan, rollback re-dirtying, ignored fields
    push_word(OP_COMMIT, 16'd0, 32'hFFFF_FFFF);
    push_word(OP_COMMIT, INDEX_W'(FRAMES_DEF - 1), '0);
    push_word(OP_COMMIT, INDEX_W'(FRAMES_DEF), '0);
    push_word(OP_COMMIT, 16'hFFFF, '0);
    push_word(OP_TAKE, 16'hFFFF, 32'hFFFF_FFFF);
    push_word(OP_TAKE, '0, '0);
    push_word(OP_TAKE, '0, '0);
    push_word(OP_CONFIRM, 16'd0, '0);
    push_word(OP_CONFIRM, INDEX_W'(FRAMES_DEF - 1), 32'hFFFF_FFFF);
    push_word(OP_CONFIRM, 16'hFFFF, 32'h1234_5678);
    push_word(OP_CONFIRM, INDEX_W'(FRAMES_DEF), 32'hFFFF_FFFF);
    push_word(OP_ROLLBACK, 16'hFFFF, 32'hFFFF_FFFF);
    push_word(OP_TAKE, '0, '0);
    push_word(OP_TAKE, '0, '0);
    push_word(OP_TAKE, '0, '0);
    push_word(OP_COMMIT, 16'd5, 32'hA5A5_A5A5);
    push_word(OP_COMMIT, 16'd5, '0);
    push_word(OP_CONFIRM, 16'd5, 32'd4);
    push_word(OP_TAKE, 16'h03FF, '0);
    push_word(OP_ROLLBACK, '0, '0);
    push_word(OP_TAKE, '0, '0);
    push_word(OP_TAKE, '0, '0);

    start = sent;
    while (sent - start < RAND_WORDS) begin
      if ($urandom_range(0, 99) < 80) begin
        k = $urandom_range(1, 6);
        repeat (k) push_word(OP_COMMIT, pick_frame(), $urandom);
        m = $urandom_range(1, k + 1);
        repeat (m) push_word(OP_TAKE, INDEX_W'($urandom), $urandom);
        repeat ($urandom_range(1, 3)) push_word(OP_CONFIRM, pick_frame(), pick_version());
        if ($urandom_range(0, 99) < 15) push_word(OP_ROLLBACK, INDEX_W'($urandom), $urandom);
      end else begin
        op = op_t'($urandom_range(0, 3));
        push_word(op, INDEX_W'($urandom), $urandom);
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (1100) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_dirty_frame_version_tracker: clean");
    end else begin
      $display("tb_dirty_frame_version_tracker: errors");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb_dirty_frame_version_tracker: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dfvt_pkg.sv
hw/rtl/dfvt_ram.sv
hw/rtl/dfvt_seq.sv
hw/rtl/dirty_frame_version_tracker.sv
hw/rtl/dfvt_checker.sv
bench/dfvt_checker.sv
bench/tb_dirty_frame_version_tracker.sv
